// File: hw/rtl/lccf_pkg.sv
// ----------------------------------------------------------------------------
// lccf_pkg
// Shared sizes, register indexes and control types of the leader cluster
// center finder.
// ----------------------------------------------------------------------------
package lccf_pkg;

   localparam int COORD_BITS  = 16;
   localparam int MAX_DIM     = 4;
   localparam int MAX_CENTERS = 256;

   localparam int DIM_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CNT_W      = $clog2(MAX_CENTERS + 1);
   localparam int CTR_W      = $clog2(MAX_CENTERS);
   localparam int RAM_DEPTH  = MAX_CENTERS * MAX_DIM;
   localparam int ADDR_W     = $clog2(RAM_DEPTH);
   localparam int SQ_W       = 2 * COORD_BITS;
   localparam int ACC_W      = SQ_W + DIM_W;
   localparam int DIMS_W     = 3;
   localparam int RADIUS_W   = 36;
   localparam int CMP_W      = (ACC_W > RADIUS_W) ? ACC_W : RADIUS_W;
   localparam int REQ_DATA_W = ((COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CNT_W + 7) / 8) * 8;
   localparam int RSP_USER_W = 2;

   localparam int REG_IDX_W  = 1;
   localparam int CSR_DATA_W = RADIUS_W;

   localparam logic [REG_IDX_W-1:0] REG_DIMENSIONS = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_RADIUS     = 1'b1;

   localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd2;

   typedef struct packed {
      logic in_ready;
      logic clr_scan;
      logic issue;
      logic latch;
      logic store;
      logic emit;
   } ctl_type;

   typedef struct packed {
      logic point_done;
      logic table_empty;
      logic scan_more;
      logic pipe_busy;
      logic no_store;
      logic copy_more;
   } sts_type;

endpackage

// File: hw/rtl/lccf_ram.sv
// ----------------------------------------------------------------------------
// lccf_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lccf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lccf_seq.sv
// ----------------------------------------------------------------------------
// lccf_seq
// Microcode sequencer: a step counter walks a small control store, and each
// control word drives the datapath and picks the next step on one condition.
// ----------------------------------------------------------------------------
module lccf_seq (
   input  logic             clock,
   input  logic             reset,
   input  lccf_pkg::sts_type sts,
   input  logic             out_busy,
   output lccf_pkg::ctl_type ctl
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_STORE,
      ST_EMIT
   } step_type;

   typedef enum logic [2:0] {
      C_ALWAYS,
      C_NOT_DONE,
      C_EMPTY,
      C_SCAN_MORE,
      C_PIPE_BUSY,
      C_NO_STORE,
      C_COPY_MORE,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      lccf_pkg::ctl_type ctl;
      cond_type          cond;
      step_type          jump_to;
      step_type          next_to;
   } uword_type;

   function automatic uword_type ucode(input step_type s);
      uword_type w;
      w         = '0;
      w.cond    = C_ALWAYS;
      w.jump_to = ST_IDLE;
      w.next_to = ST_IDLE;
      unique case (s)
         ST_IDLE: begin
            w.ctl.in_ready = 1'b1;
            w.ctl.clr_scan = 1'b1;
            w.cond         = C_NOT_DONE;
            w.jump_to      = ST_IDLE;
            w.next_to      = ST_CHECK;
         end
         ST_CHECK: begin
            w.cond    = C_EMPTY;
            w.jump_to = ST_DECIDE;
            w.next_to = ST_SCAN;
         end
         ST_SCAN: begin
            w.ctl.issue = 1'b1;
            w.cond      = C_SCAN_MORE;
            w.jump_to   = ST_SCAN;
            w.next_to   = ST_DRAIN;
         end
         ST_DRAIN: begin
            w.cond    = C_PIPE_BUSY;
            w.jump_to = ST_DRAIN;
            w.next_to = ST_DECIDE;
         end
         ST_DECIDE: begin
            w.ctl.latch = 1'b1;
            w.cond      = C_NO_STORE;
            w.jump_to   = ST_EMIT;
            w.next_to   = ST_STORE;
         end
         ST_STORE: begin
            w.ctl.store = 1'b1;
            w.cond      = C_COPY_MORE;
            w.jump_to   = ST_STORE;
            w.next_to   = ST_EMIT;
         end
         ST_EMIT: begin
            w.ctl.emit = 1'b1;
            w.cond     = C_OUT_BUSY;
            w.jump_to  = ST_EMIT;
            w.next_to  = ST_IDLE;
         end
         default: begin
            w.cond    = C_ALWAYS;
            w.jump_to = ST_IDLE;
         end
      endcase
      return w;
   endfunction

   step_type  pc_ff;
   step_type  pc_in;
   uword_type word;
   logic      taken;

   always_comb begin
      word = ucode(pc_ff);
      unique case (word.cond)
         C_ALWAYS:    taken = 1'b1;
         C_NOT_DONE:  taken = !sts.point_done;
         C_EMPTY:     taken = sts.table_empty;
         C_SCAN_MORE: taken = sts.scan_more;
         C_PIPE_BUSY: taken = sts.pipe_busy;
         C_NO_STORE:  taken = sts.no_store;
         C_COPY_MORE: taken = sts.copy_more;
         C_OUT_BUSY:  taken = out_busy;
         default:     taken = 1'b1;
      endcase
      pc_in = taken ? word.jump_to : word.next_to;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctl = word.ctl;

endmodule

// File: hw/rtl/lccf_dp.sv
// ----------------------------------------------------------------------------
// lccf_dp
// Datapath: point assembly, center memory, a three-stage distance pipeline
// (difference, square, accumulate and compare) and the center counter.
// ----------------------------------------------------------------------------
module lccf_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  lccf_pkg::ctl_type                   ctl,
   input  logic                                accept,
   input  logic [lccf_pkg::COORD_BITS-1:0]     coordinate,
   input  logic [lccf_pkg::DIMS_W-1:0]         dimensions,
   input  logic [lccf_pkg::RADIUS_W-1:0]       radius_squared,
   output lccf_pkg::sts_type                   sts,
   output logic [lccf_pkg::CNT_W-1:0]          center_count,
   output logic                                is_new_center,
   output logic                                table_full
);

   logic [lccf_pkg::COORD_BITS-1:0] buf_ff [lccf_pkg::MAX_DIM];
   logic [lccf_pkg::COORD_BITS-1:0] buf_in [lccf_pkg::MAX_DIM];
   logic [lccf_pkg::DIM_W-1:0]      idx_ff, idx_in;
   logic [lccf_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [lccf_pkg::CTR_W-1:0]      k_ff, k_in;
   logic [lccf_pkg::DIM_W-1:0]      i_ff, i_in;
   logic [lccf_pkg::DIM_W-1:0]      j_ff, j_in;
   logic                            a_vld_ff, a_vld_in, a_last_ff, a_last_in;
   logic [lccf_pkg::DIM_W-1:0]      a_idx_ff, a_idx_in;
   logic                            b_vld_ff, b_vld_in, b_last_ff, b_last_in;
   logic [lccf_pkg::COORD_BITS-1:0] b_abs_ff, b_abs_in;
   logic                            c_vld_ff, c_vld_in, c_last_ff, c_last_in;
   logic [lccf_pkg::SQ_W-1:0]       c_sq_ff, c_sq_in;
   logic [lccf_pkg::ACC_W-1:0]      acc_ff, acc_in;
   logic                            match_ff, match_in;
   logic                            new_ff, new_in;
   logic                            full_ff, full_in;

   logic [lccf_pkg::DIM_W-1:0]      nm1;
   logic [lccf_pkg::ADDR_W-1:0]     rd_addr, wr_addr;
   logic [lccf_pkg::COORD_BITS-1:0] rd_data;
   logic [lccf_pkg::COORD_BITS:0]   diff;
   logic [lccf_pkg::ACC_W-1:0]      acc_sum;
   logic                            done_now;
   logic                            at_max;

   lccf_ram #(
      .WIDTH (lccf_pkg::COORD_BITS),
      .DEPTH (lccf_pkg::RAM_DEPTH)
   ) u_centers (
      .clock   (clock),
      .wr_en   (ctl.store),
      .wr_addr (wr_addr),
      .wr_data (buf_ff[j_ff]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (dimensions == '0) begin
         nm1 = '0;
      end else if (dimensions > lccf_pkg::DIMS_W'(lccf_pkg::MAX_DIM)) begin
         nm1 = lccf_pkg::DIM_W'(lccf_pkg::MAX_DIM - 1);
      end else begin
         nm1 = lccf_pkg::DIM_W'(dimensions - 1'b1);
      end

      at_max   = (count_ff == lccf_pkg::CNT_W'(lccf_pkg::MAX_CENTERS));
      done_now = accept && (idx_ff >= nm1);
      rd_addr  = lccf_pkg::ADDR_W'(lccf_pkg::ADDR_W'(k_ff)
                 * lccf_pkg::ADDR_W'(lccf_pkg::MAX_DIM)) + lccf_pkg::ADDR_W'(i_ff);
      wr_addr  = lccf_pkg::ADDR_W'(lccf_pkg::ADDR_W'(count_ff)
                 * lccf_pkg::ADDR_W'(lccf_pkg::MAX_DIM)) + lccf_pkg::ADDR_W'(j_ff);

      buf_in   = buf_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      acc_in   = acc_ff;
      match_in = match_ff;
      new_in   = new_ff;
      full_in  = full_ff;

      if (accept) begin
         buf_in[idx_ff] = coordinate;
         idx_in         = done_now ? '0 : idx_ff + 1'b1;
      end

      a_vld_in  = ctl.issue;
      a_last_in = (i_ff == nm1);
      a_idx_in  = i_ff;
      if (ctl.issue) begin
         if (i_ff == nm1) begin
            i_in = '0;
            k_in = k_ff + 1'b1;
         end else begin
            i_in = i_ff + 1'b1;
         end
      end

      diff      = {buf_ff[a_idx_ff][lccf_pkg::COORD_BITS-1], buf_ff[a_idx_ff]}
                  - {rd_data[lccf_pkg::COORD_BITS-1], rd_data};
      b_abs_in  = diff[lccf_pkg::COORD_BITS]
                  ? lccf_pkg::COORD_BITS'(~diff + 1'b1)
                  : lccf_pkg::COORD_BITS'(diff);
      b_vld_in  = a_vld_ff;
      b_last_in = a_last_ff;

      c_sq_in   = lccf_pkg::SQ_W'(b_abs_ff) * lccf_pkg::SQ_W'(b_abs_ff);
      c_vld_in  = b_vld_ff;
      c_last_in = b_last_ff;

      acc_sum = acc_ff + lccf_pkg::ACC_W'(c_sq_ff);
      if (c_vld_ff) begin
         if (c_last_ff) begin
            acc_in = '0;
            if (lccf_pkg::CMP_W'(acc_sum) <= lccf_pkg::CMP_W'(radius_squared)) begin
               match_in = 1'b1;
            end
         end else begin
            acc_in = acc_sum;
         end
      end

      if (ctl.clr_scan) begin
         k_in     = '0;
         i_in     = '0;
         j_in     = '0;
         acc_in   = '0;
         match_in = 1'b0;
      end

      if (ctl.latch) begin
         new_in  = !match_ff && !at_max;
         full_in = !match_ff && at_max;
      end

      if (ctl.store) begin
         if (j_ff == lccf_pkg::DIM_W'(lccf_pkg::MAX_DIM - 1)) begin
            j_in     = '0;
            count_in = count_ff + 1'b1;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         count_ff  <= '0;
         k_ff      <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         a_vld_ff  <= 1'b0;
         b_vld_ff  <= 1'b0;
         c_vld_ff  <= 1'b0;
         acc_ff    <= '0;
         match_ff  <= 1'b0;
         new_ff    <= 1'b0;
         full_ff   <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         count_ff  <= count_in;
         k_ff      <= k_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         a_vld_ff  <= a_vld_in;
         b_vld_ff  <= b_vld_in;
         c_vld_ff  <= c_vld_in;
         acc_ff    <= acc_in;
         match_ff  <= match_in;
         new_ff    <= new_in;
         full_ff   <= full_in;
      end
      buf_ff    <= buf_in;
      a_last_ff <= a_last_in;
      a_idx_ff  <= a_idx_in;
      b_last_ff <= b_last_in;
      b_abs_ff  <= b_abs_in;
      c_last_ff <= c_last_in;
      c_sq_ff   <= c_sq_in;
   end

   always_comb begin
      sts.point_done  = done_now;
      sts.table_empty = (count_ff == '0);
      sts.scan_more   = !((i_ff == nm1)
                          && (lccf_pkg::CNT_W'(k_ff) == count_ff - 1'b1));
      sts.pipe_busy   = a_vld_ff || b_vld_ff || c_vld_ff;
      sts.no_store    = match_ff || at_max;
      sts.copy_more   = (j_ff != lccf_pkg::DIM_W'(lccf_pkg::MAX_DIM - 1));
   end

   assign center_count  = count_ff;
   assign is_new_center = new_ff;
   assign table_full    = full_ff;

endmodule

// File: hw/rtl/leader_cluster_center_finder.sv
// ----------------------------------------------------------------------------
// leader_cluster_center_finder
// Leader clustering: gathers coordinates into points and matches each point
// against the stored centers by squared distance, storing it when none is near.
//
// Channel  Direction  Beat contents
// req      in         tdata[15:0] coordinate (signed)
// rsp      out        tdata[8:0] center_count; tuser[0] is_new_center,
//                     tuser[1] table_full
// csr      in         csr_index register, csr_data value (36 bits)
//
// A non-final coordinate is only stored in the point buffer; a final one runs
// check, scan of one coordinate per cycle, drain, decide, copy and emit;
// a join or a full table drops the copy and an empty table the scan and drain.
// Reset holds req_tready and csr_ready low and clears control and the count.
// A stalled result register holds its beat; coordinates are still taken until
// the next point completes, whose result then waits in its emit step.
// ----------------------------------------------------------------------------
module leader_cluster_center_finder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lccf_pkg::REQ_DATA_W-1:0]     req_tdata,  // coordinate
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lccf_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // center_count
   output logic [lccf_pkg::RSP_USER_W-1:0]     rsp_tuser,  // is_new_center, table_full
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lccf_pkg::REG_IDX_W-1:0]      csr_index,
   input  logic [lccf_pkg::CSR_DATA_W-1:0]     csr_data
);

   lccf_pkg::ctl_type ctl;
   lccf_pkg::sts_type sts;

   logic [lccf_pkg::DIMS_W-1:0]   dims_ff, dims_in;
   logic [lccf_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lccf_pkg::CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                          rsp_new_ff, rsp_new_in;
   logic                          rsp_full_ff, rsp_full_in;

   logic                          accept;
   logic                          out_busy;
   logic                          rsp_load;
   logic [lccf_pkg::CNT_W-1:0]    center_count;
   logic                          is_new_center;
   logic                          table_full;

   assign accept   = req_tvalid && req_tready;
   assign out_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_load = ctl.emit && !out_busy;

   lccf_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .sts      (sts),
      .out_busy (out_busy),
      .ctl      (ctl)
   );

   lccf_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .accept         (accept),
      .coordinate     (req_tdata[lccf_pkg::COORD_BITS-1:0]),
      .dimensions     (dims_ff),
      .radius_squared (radius_ff),
      .sts            (sts),
      .center_count   (center_count),
      .is_new_center  (is_new_center),
      .table_full     (table_full)
   );

   always_comb begin
      dims_in   = dims_ff;
      radius_in = radius_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lccf_pkg::REG_DIMENSIONS: dims_in   = csr_data[lccf_pkg::DIMS_W-1:0];
            lccf_pkg::REG_RADIUS:     radius_in = csr_data[lccf_pkg::RADIUS_W-1:0];
            default: ;
         endcase
      end

      rsp_count_in = rsp_count_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_full_in  = rsp_full_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = center_count;
         rsp_new_in   = is_new_center;
         rsp_full_in  = table_full;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff      <= lccf_pkg::DIMS_RESET;
         radius_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dims_ff      <= dims_in;
         radius_ff    <= radius_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign req_tready = ctl.in_ready && !reset;
   assign csr_ready  = !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = lccf_pkg::RSP_DATA_W'(rsp_count_ff);
   assign rsp_tuser  = {rsp_full_ff, rsp_new_ff};

   a_no_accept_while_scanning: assert property (
      @(posedge clock) disable iff (reset)
      accept |-> !sts.pipe_busy
   ) else $error("coordinate accepted while the distance pipeline is busy");

   a_count_in_range: assert property (
      @(posedge clock) disable iff (reset)
      center_count <= lccf_pkg::CNT_W'(lccf_pkg::MAX_CENTERS)
   ) else $error("center count beyond table size");

   a_full_only_at_max: assert property (
      @(posedge clock) disable iff (reset)
      rsp_load && table_full |-> center_count == lccf_pkg::CNT_W'(lccf_pkg::MAX_CENTERS)
   ) else $error("table full reported below capacity");

   a_new_counts_up: assert property (
      @(posedge clock) disable iff (reset)
      rsp_load && is_new_center |-> center_count != '0 && !table_full
   ) else $error("new center reported without a stored entry");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the leader cluster center finder. Coordinates are
// streamed in bursts while the result side stalls on its own pattern, and
// every result beat is checked against a tracker that keeps its own copy of
// the center table, the point being gathered and both registers. Phases
// change the dimension count and the join radius, including partial points,
// out-of-range dimension settings, zero and maximum radius, and a full table.
// ----------------------------------------------------------------------------
module testbench;
   import lccf_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int HOLD_CYCLES = 2500;
   localparam int SETTLE_CYCLES = 64;

   typedef struct packed {
      logic             is_new_center;
      logic [CNT_W-1:0] center_count;
      logic             table_full;
   } cluster_outcome_type;

   typedef enum int {RAD_ZERO, RAD_TINY, RAD_MID, RAD_ANY, RAD_MAX} radius_kind_type;
   typedef enum int {ACCEPT_ALL, ACCEPT_RANDOM, ACCEPT_PATTERN} accept_mode_type;

   class center_tracker;
      logic [DIMS_W-1:0]          dims_reg;
      logic [RADIUS_W-1:0]        radius_reg;
      logic signed [COORD_BITS-1:0] point_buf [MAX_DIM];
      logic signed [COORD_BITS-1:0] centers [MAX_CENTERS][MAX_DIM];
      int unsigned                coord_idx;
      int unsigned                center_total;
      cluster_outcome_type        due_outcomes [$];
      int                         errors;

      function new();
         dims_reg = DIMS_RESET;
         radius_reg = '0;
         coord_idx = 0;
         center_total = 0;
         errors = 0;
      endfunction

      function void write_register(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == REG_DIMENSIONS) begin
            dims_reg = val[DIMS_W-1:0];
         end else if (idx == REG_RADIUS) begin
            radius_reg = val[RADIUS_W-1:0];
         end
      endfunction

      function int unsigned active_dims();
         if (dims_reg == 0) return 1;
         if (dims_reg > MAX_DIM) return MAX_DIM;
         return dims_reg;
      endfunction

      function longint unsigned gap_squared(int unsigned k, int unsigned n);
         longint unsigned acc;
         longint unsigned sq;
         int a;
         int b;
         int d;
         int unsigned i;
         acc = 0;
         for (i = 0; i < n; i++) begin
            a = point_buf[i];
            b = centers[k][i];
            d = (a >= b) ? a - b : b - a;
            sq = longint'(d) * longint'(d);
            if (acc > 64'hFFFF_FFFF_FFFF_FFFF - sq) acc = 64'hFFFF_FFFF_FFFF_FFFF;
            else acc = acc + sq;
         end
         return acc;
      endfunction

      function void take_coordinate(logic signed [COORD_BITS-1:0] c);
         int unsigned n;
         int unsigned k;
         int unsigned i;
         bit joined;
         cluster_outcome_type o;
         n = active_dims();
         if (coord_idx >= MAX_DIM) coord_idx = 0;
         point_buf[coord_idx] = c;
         if (coord_idx + 1 < n) begin
            coord_idx++;
            return;
         end
         coord_idx = 0;
         joined = 0;
         for (k = 0; k < center_total; k++) begin
            if (gap_squared(k, n) <= {28'd0, radius_reg}) begin
               joined = 1;
               break;
            end
         end
         o = '0;
         if (!joined) begin
            if (center_total < MAX_CENTERS) begin
               for (i = 0; i < MAX_DIM; i++) centers[center_total][i] = point_buf[i];
               center_total++;
               o.is_new_center = 1'b1;
            end else begin
               o.table_full = 1'b1;
            end
         end
         o.center_count = center_total[CNT_W-1:0];
         due_outcomes.push_back(o);
      endfunction

      function void check_outcome(logic [RSP_DATA_W-1:0] data, logic [RSP_USER_W-1:0] user);
         cluster_outcome_type want;
         cluster_outcome_type got;
         got.is_new_center = user[0];
         got.table_full = user[1];
         got.center_count = data[CNT_W-1:0];
         if (due_outcomes.size() == 0) begin
            if (errors < 10)
               $display("unexpected result beat: new=%0d count=%0d full=%0d",
                        got.is_new_center, got.center_count, got.table_full);
            errors++;
            return;
         end
         want = due_outcomes.pop_front();
         if (got.is_new_center !== want.is_new_center ||
             got.center_count !== want.center_count ||
             got.table_full !== want.table_full) begin
            if (errors < 10)
               $display({"mismatch: expected new=%0d count=%0d full=%0d,",
                         " got new=%0d count=%0d full=%0d"},
                        want.is_new_center, want.center_count, want.table_full,
                        got.is_new_center, got.center_count, got.table_full);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // coordinate
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // center_count
   logic [RSP_USER_W-1:0] rsp_tuser;   // is_new_center, table_full
   logic                  csr_valid;
   logic                  csr_ready;
   logic [REG_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   center_tracker tracker;
   int            burst_left;
   int            results_seen;
   int            cycle_count;

   leader_cluster_center_finder DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_outcome(rsp_tdata, rsp_tuser);
         results_seen++;
      end
   end

   task automatic push_coordinate(input logic signed [COORD_BITS-1:0] c);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= c;
      do @(posedge clock); while (!req_tready);
      tracker.take_coordinate(c);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (tracker.due_outcomes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_dims(input int d);
      logic [CSR_DATA_W-1:0] v;
      v = CSR_DATA_W'({$urandom(), $urandom()});
      v[DIMS_W-1:0] = d[DIMS_W-1:0];
      write_csr(REG_DIMENSIONS, v);
   endtask

   task automatic send_point(input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c, input logic [15:0] d);
      push_coordinate(a);
      push_coordinate(b);
      push_coordinate(c);
      push_coordinate(d);
   endtask

   function automatic logic [CSR_DATA_W-1:0] radius_for(radius_kind_type kind);
      logic [CSR_DATA_W-1:0] v;
      v = CSR_DATA_W'({$urandom(), $urandom()});
      case (kind)
         RAD_ZERO: v = '0;
         RAD_TINY: v = CSR_DATA_W'($urandom_range(0, 64));
         RAD_MID:  v = CSR_DATA_W'($urandom_range(0, 1 << 20));
         RAD_MAX:  v = '1;
         default: ;
      endcase
      return v;
   endfunction

   function automatic logic [COORD_BITS-1:0] pick_coordinate();
      int unsigned slot;
      int unsigned k;
      logic [COORD_BITS-1:0] v;
      slot = (tracker.coord_idx >= MAX_DIM) ? 0 : tracker.coord_idx;
      v = COORD_BITS'($urandom());
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 4))
               0: v = 16'h8000;
               1: v = 16'h7FFF;
               2: v = 16'h0000;
               3: v = 16'hFFFF;
               default: v = 16'h0001;
            endcase
         1, 2, 3, 4: ;
         default: if (tracker.center_total > 0) begin
            k = $urandom_range(0, tracker.center_total - 1);
            v = tracker.centers[k][slot] + 16'($urandom_range(0, 8)) - 16'd4;
         end
      endcase
      return v;
   endfunction

   task automatic run_phase(input int d, input radius_kind_type kind, input int items);
      settle_block();
      set_dims(d);
      write_csr(REG_RADIUS, radius_for(kind));
      repeat (items + $urandom_range(0, 3)) push_coordinate(pick_coordinate());
   endtask

   initial begin : result_side
      accept_mode_type mode;
      logic [7:0]      mask;
      int              span;
      int              step;
      bit              held;
      rsp_tready = 1'b0;
      held = 0;
      step = 0;
      mask = 8'h01;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         mode = accept_mode_type'($urandom_range(0, 2));
         mask = 8'($urandom()) | 8'h01;
         span = $urandom_range(64, 256);
         repeat (span) begin
            @(negedge clock);
            step++;
            if (!held && results_seen >= 20) begin
               held = 1;
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
            end else begin
               case (mode)
                  ACCEPT_ALL:    rsp_tready <= 1'b1;
                  ACCEPT_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
                  default:       rsp_tready <= mask[step % 8];
               endcase
            end
         end
      end
   end

   initial begin : stimulus
      int extra;
      int guard;
      tracker = new();
      burst_left = 0;
      results_seen = 0;
      cycle_count = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every buffer slot is written by the first point, so no stored center
      // ever holds an unwritten coordinate.
      set_dims(MAX_DIM);
      write_csr(REG_RADIUS, radius_for(RAD_ZERO));
      send_point(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_point(16'h8000, 16'h8000, 16'h8000, 16'h8000);

      // A distance of exactly the radius joins; one more makes a new center.
      settle_block();
      write_csr(REG_RADIUS, 36'd25);
      send_point(16'h8003, 16'h8004, 16'h8000, 16'h8000);
      send_point(16'h8003, 16'h8004, 16'h8000, 16'h8001);

      settle_block();
      write_csr(REG_RADIUS, radius_for(RAD_MAX));
      set_dims(0);
      push_coordinate(16'h0000);

      // The point is left half done and then the count drops below its index.
      settle_block();
      set_dims(7);
      write_csr(REG_RADIUS, radius_for(RAD_ZERO));
      push_coordinate(16'hFFFF);
      push_coordinate(16'h0001);
      settle_block();
      set_dims(1);
      push_coordinate(16'h5A5A);
      push_coordinate(16'h7FFF);

      run_phase(2, RAD_TINY, 70);
      run_phase(5, RAD_ZERO, 60);

      settle_block();
      set_dims(1);
      write_csr(REG_RADIUS, radius_for(RAD_ZERO));
      extra = 0;
      guard = 0;
      while ((tracker.center_total < MAX_CENTERS || extra < 20) && guard < 800) begin
         push_coordinate($urandom_range(0, 3) == 0 ? pick_coordinate() : 16'($urandom()));
         if (tracker.center_total >= MAX_CENTERS) extra++;
         guard++;
      end

      run_phase(3, RAD_ANY, 60);
      run_phase(6, RAD_MID, 50);
      run_phase(4, RAD_ZERO, 50);
      run_phase(0, RAD_MAX, 30);
      run_phase(2, RAD_TINY, 30);

      settle_block();
      if (tracker.errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
